### rtl/core/bbt_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the bracket balance tracker.
package bbt_pkg;

    // Field widths
    localparam int OP_W      = 2;
    localparam int CH_W      = 8;
    localparam int LINE_W    = 16;
    localparam int EVENT_W   = 2;
    localparam int PAIR_W    = 16;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 3;

    // Defaults for the top-level parameters
    localparam int STACK_DEPTH_DEF = 16;
    localparam int MAX_PAIRS_DEF   = 4;

    // Number of pair registers in the register map
    localparam int PAIR_REGS = 4;

    // Input operations
    typedef enum logic [OP_W-1:0] {
        OP_CHAR  = 2'd0,
        OP_EOL   = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // Result events
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE       = 2'd0,
        EV_MISMATCH   = 2'd1,
        EV_UNEXPECTED = 2'd2,
        EV_OVERFLOW   = 2'd3
    } t_event;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_ZERO  = 3'd1;

    // Reset values
    localparam logic [CNT_W-1:0] PAIR_COUNT_RESET = 3'd3;
    localparam logic [PAIR_W-1:0] PAIR_RESET [PAIR_REGS] = '{
        16'd10536, 16'd23899, 16'd32123, 16'd0
    };

    // Special characters
    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CH_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CH_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;

    typedef logic [PAIR_W-1:0] t_pair;

    // Pair lookup results
    typedef struct packed {
        logic            is_open;
        logic            is_close;
        logic [CH_W-1:0] exp_closer;
    } t_match;

    // Stack control
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_stk_ctrl;

endpackage

### rtl/core/bbt_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the bracket balance tracker: input, result and register write.
interface bbt_in_if;
    logic                        valid;
    logic                        ready;
    logic [bbt_pkg::OP_W-1:0]    op;
    logic [bbt_pkg::CH_W-1:0]    ch;
    logic [bbt_pkg::LINE_W-1:0]  line_number;

    modport source (output valid, op, ch, line_number, input ready);
    modport sink   (input valid, op, ch, line_number, output ready);
endinterface

interface bbt_out_if #(
    parameter int DEPTH_W = 5
);
    logic                        valid;
    logic                        ready;
    logic [bbt_pkg::EVENT_W-1:0] event_res;
    logic [bbt_pkg::CH_W-1:0]    top_opener;
    logic [DEPTH_W-1:0]          depth;
    logic                        inside_string;
    logic                        line_kept;
    logic                        line_complete;
    logic                        block_ready;
    logic                        has_content;
    logic [bbt_pkg::LINE_W-1:0]  first_line;

    modport source (output valid, event_res, top_opener, depth, inside_string, line_kept,
                    line_complete, block_ready, has_content, first_line, input ready);
    modport sink   (input valid, event_res, top_opener, depth, inside_string, line_kept,
                    line_complete, block_ready, has_content, first_line, output ready);
endinterface

interface bbt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bbt_pkg::CFG_IDX_W-1:0] index;
    logic [bbt_pkg::PAIR_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/bbt_pair_match.sv
`timescale 1ns / 1ps
// Parallel lookup of a character and of the stack top against the active bracket pairs.
module bbt_pair_match #(
    parameter int NUM_PAIRS = 4
) (
    input  logic [bbt_pkg::CNT_W-1:0] i_pair_count,
    input  bbt_pkg::t_pair            i_pairs [NUM_PAIRS],
    input  logic [bbt_pkg::CH_W-1:0]  i_ch,
    input  logic [bbt_pkg::CH_W-1:0]  i_top,
    output bbt_pkg::t_match           o_match
);
    import bbt_pkg::*;

    logic [CNT_W-1:0] active;

    // Counts above the stored pairs act as all pairs
    assign active = (i_pair_count > CNT_W'(NUM_PAIRS)) ? CNT_W'(NUM_PAIRS) : i_pair_count;

    // Walk from the highest pair down so the lowest matching pair wins
    always_comb begin
        o_match = '0;
        for (int i = NUM_PAIRS - 1; i >= 0; i--) begin
            if (CNT_W'(i) < active) begin
                if (i_pairs[i][CH_W-1:0] == i_ch) begin
                    o_match.is_open = 1'b1;
                end
                if (i_pairs[i][PAIR_W-1:CH_W] == i_ch) begin
                    o_match.is_close = 1'b1;
                end
                if (i_pairs[i][CH_W-1:0] == i_top) begin
                    o_match.exp_closer = i_pairs[i][PAIR_W-1:CH_W];
                end
            end
        end
    end

endmodule

### rtl/core/bbt_stack.sv
`timescale 1ns / 1ps
// Opener stack as a shift register with the top in entry zero, plus the depth counter.
module bbt_stack #(
    parameter int STACK_DEPTH = 16,
    localparam int DW = $clog2(STACK_DEPTH + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bbt_pkg::t_stk_ctrl         i_ctrl,
    input  logic [bbt_pkg::CH_W-1:0]   i_data,
    output logic [bbt_pkg::CH_W-1:0]   o_top,
    output logic [DW-1:0]              o_depth,
    output logic [DW-1:0]              o_depth_nxt,
    output logic                       o_full
);
    import bbt_pkg::*;

    logic [CH_W-1:0] r_ent [STACK_DEPTH];
    logic [DW-1:0]   r_depth;

    assign o_top   = r_ent[0];
    assign o_depth = r_depth;
    assign o_full  = (r_depth == DW'(STACK_DEPTH));

    // Next depth
    always_comb begin
        if (i_ctrl.clear) begin
            o_depth_nxt = '0;
        end else if (i_ctrl.push) begin
            o_depth_nxt = r_depth + DW'(1);
        end else if (i_ctrl.pop) begin
            o_depth_nxt = r_depth - DW'(1);
        end else begin
            o_depth_nxt = r_depth;
        end
    end

    // Depth counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= o_depth_nxt;
        end
    end

    // Entries shift down on push, up on pop
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_ent[0] <= i_data;
            for (int k = 1; k < STACK_DEPTH; k++) begin
                r_ent[k] <= r_ent[k-1];
            end
        end else if (i_ctrl.pop) begin
            for (int k = 0; k < STACK_DEPTH - 1; k++) begin
                r_ent[k] <= r_ent[k+1];
            end
        end
    end

endmodule

### rtl/core/bracket_balance_tracker.sv
`timescale 1ns / 1ps
// Top level of the bracket balance tracker: text scanner, flags, registers and result stage.
//
// Usage:
//   i_in carries one word per item: op (character, end of line, clear), the character
//   byte and the current line number. o_out returns exactly one result word per item.
//   i_cfg writes the pair count (index 0) and the four opener/closer pair registers
//   (indexes 1 to 4); writes are taken in every cycle and belong in idle time.
//   The result is registered: an accepted item shows its result in the cycle after.
//   Throughput is one item per cycle while o_out.ready stays high; the pair compares are
//   parallel and the stack top is a register, so the scanner step is combinational.
//   The result register stalls in place while o_out.ready is low, and i_in.ready then
//   drops until the held word is taken; an item is accepted in the cycle the result
//   register empties.
//   Reset empties the stack, clears every flag and the block start line, and loads the
//   pair registers with "()", "[]", "{}" and zero, three pairs active. Stack entries
//   are not cleared; only entries below the depth are ever read.
//   A clear item does the same as reset for the scan state and keeps the registers.
module bracket_balance_tracker #(
    parameter int STACK_DEPTH = bbt_pkg::STACK_DEPTH_DEF,
    parameter int MAX_PAIRS   = bbt_pkg::MAX_PAIRS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bbt_in_if.sink           i_in,
    bbt_cfg_if.sink          i_cfg,
    bbt_out_if.source        o_out
);
    import bbt_pkg::*;

    localparam int NP = (MAX_PAIRS < PAIR_REGS) ? MAX_PAIRS : PAIR_REGS;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    // Registers
    logic [CNT_W-1:0] r_pair_count;
    t_pair            r_pairs [NP];

    // Scan state
    logic             r_str, r_esc, r_cmt, r_lht, r_lsh, r_cont;
    logic [LINE_W-1:0] r_start;
    logic             n_str, n_esc, n_cmt, n_lht, n_lsh, n_cont;
    logic [LINE_W-1:0] n_start;

    // Result stage
    logic              r_ovalid;
    t_event            r_event;
    logic [CH_W-1:0]   r_top;
    logic [DW-1:0]     r_depth;
    logic              r_instr, r_kept, r_cmpl, r_blk, r_hascont;
    logic [LINE_W-1:0] r_first;

    // Step results
    t_event            w_event;
    logic [CH_W-1:0]   w_top;
    logic              w_kept, w_cmpl;
    logic              w_str_t;
    t_stk_ctrl         w_ctl, s_ctl;
    t_match            w_match;
    logic [CH_W-1:0]   s_top;
    logic [DW-1:0]     s_depth, s_depth_nxt;
    logic              s_full;
    logic              acc;

    // Handshakes
    assign i_in.ready  = !r_ovalid || o_out.ready;
    assign acc         = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // Register writes; indexes past the stored pairs are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_count <= PAIR_COUNT_RESET;
            for (int i = 0; i < NP; i++) begin
                r_pairs[i] <= PAIR_RESET[i];
            end
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_PAIR_COUNT) begin
                r_pair_count <= i_cfg.data[CNT_W-1:0];
            end
            for (int i = 0; i < NP; i++) begin
                if (i_cfg.index == REG_PAIR_ZERO + CFG_IDX_W'(i)) begin
                    r_pairs[i] <= i_cfg.data;
                end
            end
        end
    end

    bbt_pair_match #(
        .NUM_PAIRS (NP)
    ) u_match (
        .i_pair_count (r_pair_count),
        .i_pairs      (r_pairs),
        .i_ch         (i_in.ch),
        .i_top        (s_top),
        .o_match      (w_match)
    );

    // Stack only moves on an accepted word
    always_comb begin
        s_ctl.clear = w_ctl.clear && acc;
        s_ctl.push  = w_ctl.push && acc;
        s_ctl.pop   = w_ctl.pop && acc;
    end

    bbt_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (s_ctl),
        .i_data      (i_in.ch),
        .o_top       (s_top),
        .o_depth     (s_depth),
        .o_depth_nxt (s_depth_nxt),
        .o_full      (s_full)
    );

    // String flag after a possible quote toggle
    assign w_str_t = r_str ^ (i_in.ch == CH_QUOTE);

    // Scanner step
    always_comb begin
        n_str   = r_str;
        n_esc   = r_esc;
        n_cmt   = r_cmt;
        n_lht   = r_lht;
        n_lsh   = r_lsh;
        n_cont  = r_cont;
        n_start = r_start;
        w_event = EV_NONE;
        w_top   = '0;
        w_kept  = 1'b0;
        w_cmpl  = 1'b0;
        w_ctl   = '0;
        case (t_op'(i_in.op))
            OP_CHAR: begin
                // first raw non-blank character classifies the line
                if (!r_lht && i_in.ch != CH_SPACE && i_in.ch != CH_TAB) begin
                    n_lht = 1'b1;
                    n_lsh = (i_in.ch == CH_HASH);
                end
                if (r_cmt) begin
                    // rest of line ignored
                end else if (r_esc) begin
                    n_esc = 1'b0;
                end else if (i_in.ch == CH_BSLASH && r_str) begin
                    n_esc = 1'b1;
                end else begin
                    n_str = w_str_t;
                    if (!w_str_t) begin
                        if (i_in.ch == CH_HASH) begin
                            n_cmt = 1'b1;
                        end else if (w_match.is_open) begin
                            if (s_full) begin
                                w_event = EV_OVERFLOW;
                            end else begin
                                w_ctl.push = 1'b1;
                            end
                        end else if (w_match.is_close) begin
                            if (s_depth != '0) begin
                                w_ctl.pop = 1'b1;
                                if (i_in.ch != w_match.exp_closer) begin
                                    w_event = EV_MISMATCH;
                                    w_top   = s_top;
                                end
                            end else begin
                                w_event = EV_UNEXPECTED;
                            end
                        end
                    end
                end
            end
            OP_EOL: begin
                if (r_cont || (r_lht && !r_lsh)) begin
                    if (!r_cont) begin
                        n_start = i_in.line_number;
                    end
                    n_cont = 1'b1;
                    w_kept = 1'b1;
                    w_cmpl = (s_depth == '0) && !r_str;
                end
                n_cmt = 1'b0;
                n_lht = 1'b0;
                n_lsh = 1'b0;
            end
            OP_CLEAR: begin
                w_ctl.clear = 1'b1;
                n_str   = 1'b0;
                n_esc   = 1'b0;
                n_cmt   = 1'b0;
                n_lht   = 1'b0;
                n_lsh   = 1'b0;
                n_cont  = 1'b0;
                n_start = '0;
            end
            default: begin
                // unused op: status only
            end
        endcase
    end

    // Scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_str   <= 1'b0;
            r_esc   <= 1'b0;
            r_cmt   <= 1'b0;
            r_lht   <= 1'b0;
            r_lsh   <= 1'b0;
            r_cont  <= 1'b0;
            r_start <= '0;
        end else if (acc) begin
            r_str   <= n_str;
            r_esc   <= n_esc;
            r_cmt   <= n_cmt;
            r_lht   <= n_lht;
            r_lsh   <= n_lsh;
            r_cont  <= n_cont;
            r_start <= n_start;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (acc) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_event   <= w_event;
            r_top     <= w_top;
            r_depth   <= s_depth_nxt;
            r_instr   <= n_str;
            r_kept    <= w_kept;
            r_cmpl    <= w_cmpl;
            r_blk     <= (s_depth_nxt == '0) && !n_str && n_cont;
            r_hascont <= n_cont;
            r_first   <= n_start;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.event_res     = r_event;
    assign o_out.top_opener    = r_top;
    assign o_out.depth         = r_depth;
    assign o_out.inside_string = r_instr;
    assign o_out.line_kept     = r_kept;
    assign o_out.line_complete = r_cmpl;
    assign o_out.block_ready   = r_blk;
    assign o_out.has_content   = r_hascont;
    assign o_out.first_line    = r_first;

    // An accepted word always yields a result in the next cycle
    a_acc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> o_out.valid)
        else $error("accepted word produced no result");

    // Overflow is only reported with the stack full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.event_res == EV_OVERFLOW) |-> (o_out.depth == DW'(STACK_DEPTH)))
        else $error("overflow reported below full depth");

    // A complete line is a kept line and leaves the block ready
    a_cmpl_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.line_complete) |-> (o_out.line_kept && o_out.block_ready))
        else $error("complete line not kept or block not ready");

    // A pending escape exists only inside a string
    a_esc_str: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc |-> r_str)
        else $error("escape pending outside a string");

endmodule

### verif/bracket_balance_tracker_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the bracket balance tracker: directed and random text with checks.
package bbt_tb_pkg;
    import bbt_pkg::*;

    // Op code outside the defined set; the block must hold its state
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One status word as the block reports it
    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [CH_W-1:0]    top_opener;
        logic [4:0]         depth;
        logic               inside_string;
        logic               line_kept;
        logic               line_complete;
        logic               block_ready;
        logic               has_content;
        logic [LINE_W-1:0]  first_line;
    } t_scan_status;

    // Shadow of the scanner and the queue of status words still owed
    class bracket_scoreboard;
        logic [CNT_W-1:0]  pair_cnt;
        logic [PAIR_W-1:0] pair_reg [PAIR_REGS];
        logic [CH_W-1:0]   opener_mem [STACK_DEPTH_DEF];
        int unsigned       nest;
        bit                in_str;
        bit                esc_pend;
        bit                in_comment;
        bit                line_text;
        bit                line_hash;
        bit                content;
        logic [LINE_W-1:0] blk_start;
        t_scan_status      pending_status [$];
        int                errors;

        function new();
            pair_cnt = PAIR_COUNT_RESET;
            foreach (pair_reg[i]) pair_reg[i] = PAIR_RESET[i];
            errors = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            nest       = 0;
            in_str     = 0;
            esc_pend   = 0;
            in_comment = 0;
            line_text  = 0;
            line_hash  = 0;
            content    = 0;
            blk_start  = '0;
        endfunction

        function int unsigned live_pairs();
            int unsigned n;
            n = pair_cnt;
            if (n > MAX_PAIRS_DEF) n = MAX_PAIRS_DEF;
            if (n > PAIR_REGS) n = PAIR_REGS;
            return n;
        endfunction

        // Lowest numbered live pair whose opener is c
        function bit opener_of(logic [CH_W-1:0] c, output logic [CH_W-1:0] closer);
            int i;
            closer = '0;
            for (i = 0; i < live_pairs(); i++) begin
                if (pair_reg[i][7:0] == c) begin
                    closer = pair_reg[i][15:8];
                    return 1;
                end
            end
            return 0;
        endfunction

        function bit closer_of(logic [CH_W-1:0] c);
            int i;
            for (i = 0; i < live_pairs(); i++)
                if (pair_reg[i][15:8] == c) return 1;
            return 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAIR_W-1:0] data);
            if (idx == REG_PAIR_COUNT)
                pair_cnt = data[CNT_W-1:0];
            else if (idx >= REG_PAIR_ZERO && idx < REG_PAIR_ZERO + PAIR_REGS)
                pair_reg[idx - REG_PAIR_ZERO] = data;
        endfunction

        // Advance the shadow by one accepted word and queue its status
        function void scan_item(logic [OP_W-1:0] op, logic [CH_W-1:0] c,
                                logic [LINE_W-1:0] ln);
            t_scan_status st;
            logic [CH_W-1:0] closer;
            logic [CH_W-1:0] top_ch;
            logic [CH_W-1:0] want;
            st = '0;
            if (op == OP_CHAR) begin
                // blank and leading-hash detection looks at the raw character
                if (!line_text && c != CH_SPACE && c != CH_TAB) begin
                    line_text = 1;
                    line_hash = (c == CH_HASH);
                end
                if (!in_comment) begin
                    if (esc_pend) begin
                        esc_pend = 0;
                    end else if (c == CH_BSLASH && in_str) begin
                        esc_pend = 1;
                    end else begin
                        if (c == CH_QUOTE) in_str = !in_str;
                        if (!in_str) begin
                            if (c == CH_HASH) begin
                                in_comment = 1;
                            end else if (opener_of(c, closer)) begin
                                if (nest < STACK_DEPTH_DEF) begin
                                    opener_mem[nest] = c;
                                    nest++;
                                end else begin
                                    st.event_res = EV_OVERFLOW;
                                end
                            end else if (closer_of(c)) begin
                                if (nest > 0) begin
                                    top_ch = opener_mem[nest-1];
                                    // an opener no longer configured expects zero
                                    if (!opener_of(top_ch, want)) want = '0;
                                    if (c != want) begin
                                        st.event_res  = EV_MISMATCH;
                                        st.top_opener = top_ch;
                                    end
                                    nest--;
                                end else begin
                                    st.event_res = EV_UNEXPECTED;
                                end
                            end
                        end
                    end
                end
            end else if (op == OP_EOL) begin
                if (content || (line_text && !line_hash)) begin
                    if (!content) blk_start = ln;
                    content          = 1;
                    st.line_kept     = 1;
                    st.line_complete = (nest == 0) && !in_str;
                end
                in_comment = 0;
                line_text  = 0;
                line_hash  = 0;
            end else if (op == OP_CLEAR) begin
                clear_scan();
            end
            st.depth         = 5'(nest);
            st.inside_string = in_str;
            st.block_ready   = (nest == 0) && !in_str && content;
            st.has_content   = content;
            st.first_line    = blk_start;
            pending_status.insert(pending_status.size(), st);
        endfunction

        function void field_check(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_status(t_scan_status got);
            t_scan_status want;
            if (pending_status.size() == 0) begin
                $error("status word with nothing pending");
                errors++;
                return;
            end
            want = pending_status.pop_front();
            field_check("event_res", 16'(want.event_res), 16'(got.event_res));
            field_check("top_opener", 16'(want.top_opener), 16'(got.top_opener));
            field_check("depth", 16'(want.depth), 16'(got.depth));
            field_check("inside_string", 16'(want.inside_string), 16'(got.inside_string));
            field_check("line_kept", 16'(want.line_kept), 16'(got.line_kept));
            field_check("line_complete", 16'(want.line_complete), 16'(got.line_complete));
            field_check("block_ready", 16'(want.block_ready), 16'(got.block_ready));
            field_check("has_content", 16'(want.has_content), 16'(got.has_content));
            field_check("first_line", want.first_line, got.first_line);
        endfunction
    endclass
endpackage

module bracket_balance_tracker_tb;
    import bbt_pkg::*;
    import bbt_tb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bbt_in_if  in_ch ();
    bbt_out_if out_ch ();
    bbt_cfg_if cfg_ch ();

    bracket_balance_tracker DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    bracket_scoreboard sb;

    int tx_idle_pct = 16;
    int rx_idle_pct = 79;
    int items_fed   = 0;
    logic [LINE_W-1:0] line_ctr = '0;
    logic [CNT_W-1:0]  cur_cnt;
    logic [PAIR_W-1:0] cur_pair [PAIR_REGS];

    always #2 i_clk = ~i_clk;

    // Run limit, well above the slowest legal run
    initial begin
        #2000000;
        $display("bracket_balance_tracker_tb: done, errors");
        $finish;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watch all three channels at the clock edge
    always @(posedge i_clk) begin
        t_scan_status got;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.event_res     = out_ch.event_res;
                got.top_opener    = out_ch.top_opener;
                got.depth         = out_ch.depth;
                got.inside_string = out_ch.inside_string;
                got.line_kept     = out_ch.line_kept;
                got.line_complete = out_ch.line_complete;
                got.block_ready   = out_ch.block_ready;
                got.has_content   = out_ch.has_content;
                got.first_line    = out_ch.first_line;
                sb.check_status(got);
            end
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                sb.scan_item(in_ch.op, in_ch.ch, in_ch.line_number);
        end
    end

    function automatic int live_count();
        return (cur_cnt > PAIR_REGS) ? PAIR_REGS : int'(cur_cnt);
    endfunction

    function automatic void pick_pair(output logic [CH_W-1:0] op_c,
                                      output logic [CH_W-1:0] cl_c);
        int i;
        i    = $urandom_range(live_count() - 1);
        op_c = cur_pair[i][7:0];
        cl_c = cur_pair[i][15:8];
    endfunction

    // Character mix weighted toward the bytes the scanner cares about
    function automatic logic [CH_W-1:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 22 && live_count() > 0) return cur_pair[$urandom_range(live_count() - 1)][7:0];
        if (r < 40) return cur_pair[$urandom_range(PAIR_REGS - 1)][15:8];
        if (r < 46) return CH_QUOTE;
        if (r < 51) return CH_BSLASH;
        if (r < 54) return CH_HASH;
        if (r < 64) return $urandom_range(1) ? CH_SPACE : CH_TAB;
        if (r < 90) return 8'h61 + 8'($urandom_range(25));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [PAIR_W-1:0] mk_pair(logic [CH_W-1:0] op_c, logic [CH_W-1:0] cl_c);
        return {cl_c, op_c};
    endfunction

    // Send one word, with random idle cycles ahead of it
    task automatic feed_item(logic [OP_W-1:0] op, logic [CH_W-1:0] c, logic [LINE_W-1:0] ln);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= op;
        in_ch.ch          <= c;
        in_ch.line_number <= ln;
        do @(posedge i_clk); while (!in_ch.ready);
        items_fed++;
    endtask

    task automatic feed_char(logic [CH_W-1:0] c);
        feed_item(OP_CHAR, c, LINE_W'($urandom_range(16'hFFFF)));
    endtask

    task automatic feed_eol();
        if ($urandom_range(9) == 0) line_ctr = LINE_W'($urandom_range(16'hFFFF));
        else line_ctr = line_ctr + 1'b1;
        feed_item(OP_EOL, CH_W'($urandom_range(255)), line_ctr);
    endtask

    task automatic feed_text(string s);
        for (int i = 0; i < s.len(); i++) feed_char(s[i]);
    endtask

    // Stop sending, let every owed status word arrive, then let the block idle
    task automatic settle();
        in_ch.valid <= 1'b0;
        // wait for the edge at which the last accepted word is queued
        @(posedge i_clk);
        while (sb.pending_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_word(logic [CFG_IDX_W-1:0] idx, logic [PAIR_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Write the count word and all four pairs; set is {pair3, pair2, pair1, pair0}
    task automatic program_regs(logic [PAIR_W-1:0] cnt_word, logic [4*PAIR_W-1:0] set);
        int i;
        write_word(REG_PAIR_COUNT, cnt_word);
        for (i = 0; i < PAIR_REGS; i++)
            write_word(REG_PAIR_ZERO + CFG_IDX_W'(i), set[i*PAIR_W +: PAIR_W]);
        cfg_ch.valid <= 1'b0;
        cur_cnt = cnt_word[CNT_W-1:0];
        for (i = 0; i < PAIR_REGS; i++) cur_pair[i] = set[i*PAIR_W +: PAIR_W];
    endtask

    // One random line: mostly well-formed nesting, some blank, noise, deep bursts or a clear
    task automatic gen_line();
        int r;
        int k;
        int steps;
        logic [CH_W-1:0] op_c;
        logic [CH_W-1:0] cl_c;
        logic [CH_W-1:0] want_q [$];
        r = $urandom_range(99);
        if (r < 55) begin
            steps = $urandom_range(1, 12);
            repeat (steps) begin
                k = $urandom_range(99);
                if (k < 35 && live_count() > 0 && want_q.size() < 10) begin
                    pick_pair(op_c, cl_c);
                    feed_char(op_c);
                    want_q.insert(want_q.size(), cl_c);
                end else if (k < 55 && want_q.size() > 0) begin
                    cl_c = want_q[$];
                    want_q.delete(want_q.size() - 1);
                    feed_char(cl_c);
                end else if (k < 65) begin
                    // quoted string, escapes may hide a quote
                    feed_char(CH_QUOTE);
                    repeat ($urandom_range(0, 5)) begin
                        if ($urandom_range(4) == 0) feed_char(CH_BSLASH);
                        feed_char(pick_char());
                    end
                    feed_char(CH_QUOTE);
                end else if (k < 75) begin
                    feed_char(pick_char());
                end else begin
                    feed_char($urandom_range(3) == 0 ? CH_SPACE : 8'h61 + 8'($urandom_range(25)));
                end
            end
            k = $urandom_range(99);
            if (k < 80) begin
                while (want_q.size() > 0) begin
                    cl_c = want_q[$];
                    want_q.delete(want_q.size() - 1);
                    feed_char(cl_c);
                end
            end
            if (k >= 90) begin
                feed_char(CH_HASH);
                repeat ($urandom_range(0, 4)) feed_char(pick_char());
            end
            feed_eol();
        end else if (r < 70) begin
            // blank or comment-only line
            repeat ($urandom_range(0, 3)) feed_char($urandom_range(1) ? CH_SPACE : CH_TAB);
            if ($urandom_range(1)) begin
                feed_char(CH_HASH);
                repeat ($urandom_range(0, 4)) feed_char(pick_char());
            end
            feed_eol();
        end else if (r < 86) begin
            repeat ($urandom_range(1, 10)) begin
                k = $urandom_range(99);
                if (k < 85) feed_char(pick_char());
                else if (k < 93) feed_eol();
                else if (k < 97)
                    feed_item(OP_UNUSED, CH_W'($urandom_range(255)),
                              LINE_W'($urandom_range(16'hFFFF)));
                else
                    feed_item(OP_CLEAR, CH_W'($urandom_range(255)),
                              LINE_W'($urandom_range(16'hFFFF)));
            end
        end else if (r < 95 && live_count() > 0) begin
            // deep nesting, runs past the stack limit most of the time
            repeat ($urandom_range(14, 20)) begin
                pick_pair(op_c, cl_c);
                feed_char(op_c);
                want_q.insert(want_q.size(), cl_c);
            end
            while (want_q.size() > 0) begin
                cl_c = want_q[$];
                want_q.delete(want_q.size() - 1);
                feed_char($urandom_range(6) == 0 ? pick_char() : cl_c);
            end
            feed_eol();
        end else begin
            feed_item(OP_CLEAR, CH_W'($urandom_range(255)), LINE_W'($urandom_range(16'hFFFF)));
        end
    endtask

    // Random lines, then leave openers on the stack for the next settings
    task automatic run_phase(int target);
        int start;
        logic [CH_W-1:0] op_c;
        logic [CH_W-1:0] cl_c;
        start = items_fed;
        while (items_fed - start < target) gen_line();
        feed_eol();
        if (sb.in_str) feed_char(CH_QUOTE);
        if (live_count() > 0) begin
            repeat (3) begin
                pick_pair(op_c, cl_c);
                feed_char(op_c);
            end
        end
        settle();
    endtask

    initial begin
        int i;
        sb = new();
        cur_cnt = PAIR_COUNT_RESET;
        for (i = 0; i < PAIR_REGS; i++) cur_pair[i] = PAIR_RESET[i];
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.op          = OP_CHAR;
        in_ch.ch          = '0;
        in_ch.line_number = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_PAIR_COUNT;
        cfg_ch.data       = '0;
        out_ch.ready      = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: blank line, comment-only line, strings with escapes,
        // mismatch, closer on empty stack, escape pending over end of line,
        // unused op, clear, byte and line number extremes
        feed_item(OP_EOL, 8'h41, 16'd1);
        feed_text(" #(");
        feed_item(OP_EOL, 8'h00, 16'd2);
        feed_text("\t(\"\\\")\"");
        feed_text("]}");
        feed_text("\"\\");
        feed_item(OP_EOL, 8'hFF, 16'd3);
        feed_text("x\"");
        feed_item(OP_EOL, 8'h00, 16'hFFFF);
        feed_item(OP_UNUSED, 8'h28, 16'h1234);
        feed_item(OP_CLEAR, 8'h5B, 16'hABCD);
        feed_char(8'h00);
        feed_char(8'hFF);
        feed_item(OP_EOL, 8'h7F, 16'h0000);

        // Reset pairs
        run_phase(270);

        // Opener equal to its closer, and a closer that is also an opener
        program_regs(16'd4, {mk_pair("[", "("), mk_pair("|", "|"),
                             mk_pair("<", ">"), mk_pair("(", ")")});
        run_phase(270);

        // Count word all ones, byte extremes, two pairs with one opener
        tx_idle_pct = 79;
        rx_idle_pct = 16;
        program_regs(16'hFFFF, {mk_pair("{", ")"), mk_pair("{", "}"),
                                mk_pair(8'hFF, 8'hFF), mk_pair(8'h00, 8'h00)});
        run_phase(270);

        // Fewer pairs: stacked openers lose their pair
        program_regs(16'd2, {16'h0000, 16'h0000, mk_pair("[", "]"), mk_pair("(", ")")});
        run_phase(270);

        // No pairs at all
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_regs(16'd0, {16'hFFFF, mk_pair("<", ">"), mk_pair("{", "}"),
                             mk_pair("(", ")")});
        run_phase(150);

        // Random pairs
        program_regs(16'($urandom_range(1, 4)),
                     {16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                      16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF))});
        run_phase(270);

        settle();
        if (sb.errors == 0)
            $display("bracket_balance_tracker_tb: done, clean");
        else
            $display("bracket_balance_tracker_tb: done, errors");
        $finish;
    end
endmodule

### files.f
rtl/core/bbt_pkg.sv
rtl/core/bbt_if.sv
rtl/core/bbt_pair_match.sv
rtl/core/bbt_stack.sv
rtl/core/bracket_balance_tracker.sv
verif/bracket_balance_tracker_tb.sv
